>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, off during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> design/jbst_pkg.sv
`timescale 1ns / 1ps

package jbst_pkg;

  localparam longint unsigned MAX_DOCUMENT_BYTES = 64'd16777216;
  localparam longint unsigned TOP24 = 64'hFF_FFFF;
  localparam logic [23:0] POS_TOP =
    (MAX_DOCUMENT_BYTES == 64'd0 || MAX_DOCUMENT_BYTES - 64'd1 > TOP24) ?
    24'hFF_FFFF : 24'(MAX_DOCUMENT_BYTES - 64'd1);

  // Scan modes
  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_STR    = 4'd1;
  localparam logic [3:0] M_ESC    = 4'd2;
  localparam logic [3:0] M_KEY    = 4'd3;
  localparam logic [3:0] M_NSIGN  = 4'd4;
  localparam logic [3:0] M_NINT   = 4'd5;
  localparam logic [3:0] M_NDOT   = 4'd6;
  localparam logic [3:0] M_NFRAC  = 4'd7;
  localparam logic [3:0] M_NE     = 4'd8;
  localparam logic [3:0] M_NESIGN = 4'd9;
  localparam logic [3:0] M_NEXP   = 4'd10;
  localparam logic [3:0] M_NBAD   = 4'd11;

  // Token kinds
  localparam logic [3:0] KIND_INVALID = 4'd0;
  localparam logic [3:0] KIND_END     = 4'd1;
  localparam logic [3:0] KIND_LBRACE  = 4'd2;
  localparam logic [3:0] KIND_RBRACE  = 4'd3;
  localparam logic [3:0] KIND_LBRACK  = 4'd4;
  localparam logic [3:0] KIND_RBRACK  = 4'd5;
  localparam logic [3:0] KIND_STRING  = 4'd6;
  localparam logic [3:0] KIND_COLON   = 4'd7;
  localparam logic [3:0] KIND_COMMA   = 4'd8;
  localparam logic [3:0] KIND_TRUE    = 4'd9;
  localparam logic [3:0] KIND_FALSE   = 4'd10;
  localparam logic [3:0] KIND_NULL    = 4'd11;
  localparam logic [3:0] KIND_NUMBER  = 4'd12;

  // Keyword choices
  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef struct packed {
    logic [3:0]  kind;
    logic [23:0] start;
    logic [23:0] length;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] kind;
  } close_t;

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_VT;
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LBRACK: k = KIND_LBRACK;
      CH_RBRACK: k = KIND_RBRACK;
      CH_COLON:  k = KIND_COLON;
      CH_COMMA:  k = KIND_COMMA;
      default:   k = KIND_INVALID;
    endcase
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] ch);
    logic [2:0] n;
    unique case (ch)
      KW_TRUE:  n = 3'd4;
      KW_FALSE: n = 3'd5;
      KW_NULL:  n = 3'd4;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] kw_kind(input logic [1:0] ch);
    logic [3:0] k;
    unique case (ch)
      KW_TRUE:  k = KIND_TRUE;
      KW_FALSE: k = KIND_FALSE;
      KW_NULL:  k = KIND_NULL;
      default:  k = KIND_INVALID;
    endcase
    return k;
  endfunction

  // Expected letter of a keyword; positions past its length are never compared.
  function automatic logic [7:0] kw_char(input logic [1:0] ch, input logic [2:0] p);
    logic [7:0] c;
    unique case ({ch, p})
      {KW_TRUE, 3'd0}:  c = CH_T;
      {KW_TRUE, 3'd1}:  c = CH_R;
      {KW_TRUE, 3'd2}:  c = CH_U;
      {KW_TRUE, 3'd3}:  c = CH_E;
      {KW_FALSE, 3'd0}: c = CH_F;
      {KW_FALSE, 3'd1}: c = CH_A;
      {KW_FALSE, 3'd2}: c = CH_L;
      {KW_FALSE, 3'd3}: c = CH_S;
      {KW_FALSE, 3'd4}: c = CH_E;
      {KW_NULL, 3'd0}:  c = CH_N;
      {KW_NULL, 3'd1}:  c = CH_U;
      {KW_NULL, 3'd2}:  c = CH_L;
      {KW_NULL, 3'd3}:  c = CH_L;
      default:          c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic close_t close_kind(input logic [3:0] m, input logic [1:0] ch,
                                        input logic [2:0] prog, input logic match);
    close_t r;
    r.hit  = 1'b0;
    r.kind = KIND_INVALID;
    if (m == M_STR || m == M_ESC) begin
      r.hit = 1'b1;
    end else if (m == M_KEY) begin
      r.hit = 1'b1;
      if (match && kw_len(ch) != 3'd0 && prog == kw_len(ch)) r.kind = kw_kind(ch);
    end else if (m >= M_NSIGN && m <= M_NBAD) begin
      r.hit = 1'b1;
      if (m == M_NINT || m == M_NFRAC || m == M_NEXP) r.kind = KIND_NUMBER;
    end
    return r;
  endfunction

  function automatic logic [23:0] sat_len(input logic [24:0] stop, input logic [23:0] first);
    logic [24:0] d;
    d = stop - {1'b0, first};
    if (stop < {1'b0, first}) d = 25'd0;
    return d[24] ? 24'hFF_FFFF : d[23:0];
  endfunction

  function automatic logic [3:0] number_next(input logic [3:0] m, input logic [7:0] c);
    logic       d;
    logic       e;
    logic [3:0] n;
    d = is_digit(c);
    e = c == CH_E || c == CH_UP_E;
    unique case (m)
      M_NSIGN:  n = d ? M_NINT : M_NBAD;
      M_NINT:   n = d ? M_NINT : (c == CH_DOT ? M_NDOT : (e ? M_NE : M_NBAD));
      M_NDOT:   n = d ? M_NFRAC : M_NBAD;
      M_NFRAC:  n = d ? M_NFRAC : (e ? M_NE : M_NBAD);
      M_NE:     n = d ? M_NEXP : ((c == CH_PLUS || c == CH_MINUS) ? M_NESIGN : M_NBAD);
      M_NESIGN: n = d ? M_NEXP : M_NBAD;
      M_NEXP:   n = d ? M_NEXP : M_NBAD;
      default:  n = M_NBAD;
    endcase
    return n;
  endfunction

endpackage

>>> design/json_byte_stream_tokenizer.sv
// Output: tokens caused by a byte are registered into the token queue on its transfer and leave in order.
// Throughput: one byte per cycle while each byte yields at most one token and out_ready
//   is held high; a byte may yield up to three tokens, and the four-entry token queue drops
//   in_ready while more than one token is waiting.
// Reset: synchronous, active high; clears scan state, byte offset and the token queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module json_byte_stream_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  token_kind,
  output logic [23:0] token_start,
  output logic [23:0] token_length,
  output logic        run_last
);
  import jbst_pkg::*;

  // Scan state
  logic [3:0]  mode, mode_next;
  logic [23:0] token_begin, token_begin_next;
  logic [23:0] byte_position, byte_position_next;
  logic [1:0]  kw_choice, kw_choice_next;
  logic [2:0]  kw_progress, kw_progress_next;
  logic        kw_match, kw_match_next;
  logic        doc_ended, doc_ended_next;

  // Token queue
  tok_t        fifo [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count;

  logic        accept, pop;
  logic [23:0] pos, pos_after;
  logic [24:0] pos_end;
  logic        sep, do_start;
  logic [3:0]  pk;
  close_t      cl_now, cl_fin;
  logic [3:0]  res_kind [3];
  logic [23:0] res_start [3];
  logic [23:0] res_len [3];
  logic [1:0]  res_cnt;
  logic [2:0]  push_cnt;
  logic        scan_clear;
  logic        zero_transfer;

  assign accept    = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign in_ready  = count <= 3'd1;
  assign out_valid = count != 3'd0;

  assign pos       = (byte_position > POS_TOP) ? POS_TOP : byte_position;
  assign pos_end   = {1'b0, pos} + 25'd1;
  assign pos_after = (pos < POS_TOP) ? pos + 24'd1 : POS_TOP;
  assign pk        = punct_kind(data_byte);
  assign sep       = is_space(data_byte) || pk != KIND_INVALID;
  assign cl_now    = close_kind(mode, kw_choice, kw_progress, kw_match);

  always_comb begin
    mode_next          = mode;
    token_begin_next   = token_begin;
    byte_position_next = byte_position;
    kw_choice_next     = kw_choice;
    kw_progress_next   = kw_progress;
    kw_match_next      = kw_match;
    doc_ended_next     = doc_ended;
    do_start           = 1'b0;
    cl_fin             = '0;
    res_cnt            = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res_kind[i]  = KIND_INVALID;
      res_start[i] = '0;
      res_len[i]   = '0;
    end

    if (doc_ended) begin
      if (last_byte) begin
        mode_next          = M_IDLE;
        token_begin_next   = '0;
        byte_position_next = '0;
        kw_choice_next     = '0;
        kw_progress_next   = '0;
        kw_match_next      = 1'b1;
        doc_ended_next     = 1'b0;
      end
    end else if (data_byte == CH_NUL) begin
      if (cl_now.hit) begin
        res_kind[res_cnt]  = cl_now.kind;
        res_start[res_cnt] = token_begin;
        res_len[res_cnt]   = sat_len({1'b0, pos}, token_begin);
        res_cnt            = res_cnt + 2'd1;
      end
      res_kind[res_cnt]  = KIND_END;
      res_start[res_cnt] = pos;
      res_len[res_cnt]   = '0;
      res_cnt            = res_cnt + 2'd1;
      mode_next          = M_IDLE;
      if (last_byte) begin
        token_begin_next   = '0;
        byte_position_next = '0;
        kw_choice_next     = '0;
        kw_progress_next   = '0;
        kw_match_next      = 1'b1;
      end else begin
        doc_ended_next = 1'b1;
      end
    end else begin
      if (mode == M_STR) begin
        if (data_byte == CH_QUOTE) begin
          res_kind[res_cnt]  = KIND_STRING;
          res_start[res_cnt] = token_begin;
          res_len[res_cnt]   = sat_len(pos_end, token_begin);
          res_cnt            = res_cnt + 2'd1;
          mode_next          = M_IDLE;
        end else if (data_byte == CH_BSLASH) begin
          mode_next = M_ESC;
        end
      end else if (mode == M_ESC) begin
        mode_next = M_STR;
      end else if (mode >= M_KEY && mode <= M_NBAD) begin
        if (sep) begin
          // separator closes the pending token, then gets its own turn
          res_kind[res_cnt]  = cl_now.kind;
          res_start[res_cnt] = token_begin;
          res_len[res_cnt]   = sat_len({1'b0, pos}, token_begin);
          res_cnt            = res_cnt + 2'd1;
          mode_next          = M_IDLE;
          do_start           = 1'b1;
        end else if (mode == M_KEY) begin
          if (kw_choice == 2'd3 || kw_progress >= kw_len(kw_choice) ||
              kw_char(kw_choice, kw_progress) != data_byte) begin
            kw_match_next = 1'b0;
          end
          if (kw_progress != 3'd7) kw_progress_next = kw_progress + 3'd1;
        end else begin
          mode_next = number_next(mode, data_byte);
        end
      end else begin
        mode_next = M_IDLE;
        do_start  = 1'b1;
      end

      if (do_start && !is_space(data_byte)) begin
        if (pk != KIND_INVALID) begin
          res_kind[res_cnt]  = pk;
          res_start[res_cnt] = pos;
          res_len[res_cnt]   = 24'd1;
          res_cnt            = res_cnt + 2'd1;
        end else begin
          token_begin_next = pos;
          if (data_byte == CH_QUOTE) begin
            mode_next = M_STR;
          end else if (data_byte == CH_T || data_byte == CH_F || data_byte == CH_N) begin
            mode_next        = M_KEY;
            kw_choice_next   = (data_byte == CH_T) ? KW_TRUE :
                               ((data_byte == CH_F) ? KW_FALSE : KW_NULL);
            kw_progress_next = 3'd1;
            kw_match_next    = 1'b1;
          end else if (data_byte == CH_MINUS) begin
            mode_next = M_NSIGN;
          end else if (is_digit(data_byte)) begin
            mode_next = M_NINT;
          end else begin
            res_kind[res_cnt]  = KIND_INVALID;
            res_start[res_cnt] = pos;
            res_len[res_cnt]   = 24'd1;
            res_cnt            = res_cnt + 2'd1;
          end
        end
      end

      if (last_byte) begin
        cl_fin = close_kind(mode_next, kw_choice_next, kw_progress_next, kw_match_next);
        if (cl_fin.hit) begin
          res_kind[res_cnt]  = cl_fin.kind;
          res_start[res_cnt] = token_begin_next;
          res_len[res_cnt]   = sat_len(pos_end, token_begin_next);
          res_cnt            = res_cnt + 2'd1;
        end
        res_kind[res_cnt]  = KIND_END;
        res_start[res_cnt] = pos_after;
        res_len[res_cnt]   = '0;
        res_cnt            = res_cnt + 2'd1;
        mode_next          = M_IDLE;
        token_begin_next   = '0;
        byte_position_next = '0;
        kw_choice_next     = '0;
        kw_progress_next   = '0;
        kw_match_next      = 1'b1;
      end else begin
        byte_position_next = pos_after;
      end
    end
  end

  assign push_cnt = accept ? {1'b0, res_cnt} : 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      token_begin   <= '0;
      byte_position <= '0;
      kw_choice     <= '0;
      kw_progress   <= '0;
      kw_match      <= 1'b1;
      doc_ended     <= 1'b0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (accept) begin
        mode          <= mode_next;
        token_begin   <= token_begin_next;
        byte_position <= byte_position_next;
        kw_choice     <= kw_choice_next;
        kw_progress   <= kw_progress_next;
        kw_match      <= kw_match_next;
        doc_ended     <= doc_ended_next;
      end
      wr_ptr <= wr_ptr + push_cnt[1:0];
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + push_cnt - {2'b00, pop};
    end
  end

  // Queue payload: write the tokens of one transfer in order, flag the final one.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (accept && 2'(i) < res_cnt) begin
        fifo[wr_ptr + 2'(i)] <= '{kind:   res_kind[i],
                                  start:  res_start[i],
                                  length: res_len[i],
                                  last:   2'(i) == res_cnt - 2'd1};
      end
    end
  end

  assign token_kind   = fifo[rd_ptr].kind;
  assign token_start  = fifo[rd_ptr].start;
  assign token_length = fifo[rd_ptr].length;
  assign run_last     = fifo[rd_ptr].last;

  assign scan_clear    = mode == M_IDLE && byte_position == 24'd0 && !doc_ended;
  assign zero_transfer = accept && !doc_ended && data_byte == CH_NUL && !last_byte;

  `ASSERT_NEVER(a_queue_bound, count > 3'd4, "token queue overflow")
  `ASSERT_CLK(a_last_resets, accept && last_byte |=> scan_clear, "state not reset after last byte")
  `ASSERT_CLK(a_zero_ends, zero_transfer |=> doc_ended, "zero byte did not end document")
  `ASSERT_CLK(a_end_flagged, out_valid && token_kind == KIND_END |-> run_last, "end token not final")

endmodule
